FILE: hdl/tbd_pkg.sv
// shared types, constants and small decode functions for the thermometer display core
// no dependencies

package tbd_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int PROD_W      = 24;
   localparam int TEMP_W      = 13;
   localparam int REM_W       = 12;
   localparam int QUOT_W      = 12;
   localparam int OFFSET_W    = 10;
   localparam int LIMIT_W     = 12;
   localparam int WHOLE_W     = 10;
   localparam int HUNDREDS_W  = 7;
   localparam int DIGIT_W     = 4;
   localparam int SEG_W       = 7;
   localparam int POS_W       = 2;
   localparam int BAND_W      = 2;
   localparam int ANGLE_W     = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int NUM_DIGITS  = 4;

   // scale factor sample*3300/4095
   localparam logic [SAMPLE_W-1:0] SCALE_NUM = 12'd3300;
   localparam logic [SAMPLE_W:0]   SCALE_DEN = 13'd4095;
   localparam int                  DEN_SHIFT = 12;

   // reciprocal constants for the decimal split
   localparam int                 RECIP_SHIFT = 19;
   localparam logic [15:0]        RECIP_10    = 16'd52429;
   localparam logic [12:0]        RECIP_100   = 13'd5243;
   localparam int                 SMALL_SHIFT = 7;
   localparam logic [3:0]         SMALL_RECIP = 4'd13;
   localparam logic [3:0]         DEC_BASE    = 4'd10;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_LIMIT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_LIMIT = 2'd2;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET     = 10'd260;
   localparam logic [LIMIT_W-1:0]  LOW_LIMIT_RESET  = 12'd370;
   localparam logic [LIMIT_W-1:0]  HIGH_LIMIT_RESET = 12'd375;

   localparam logic [BAND_W-1:0] BAND_LOW  = 2'd0;
   localparam logic [BAND_W-1:0] BAND_MID  = 2'd1;
   localparam logic [BAND_W-1:0] BAND_HIGH = 2'd2;

   localparam logic [ANGLE_W-1:0] ANGLE_LOW  = 7'd0;
   localparam logic [ANGLE_W-1:0] ANGLE_MID  = 7'd45;
   localparam logic [ANGLE_W-1:0] ANGLE_HIGH = 7'd90;

   localparam logic [POS_W-1:0] POS_UNITS = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;
   localparam int OUT_DEPTH   = 2;
   localparam int OUT_PTR_W   = 1;
   localparam int OUT_CNT_W   = 2;

   typedef struct packed {
      logic              cmd;
      logic [PROD_W-1:0] prod;
   } work_type;

   typedef struct packed {
      logic [SEG_W-1:0]   segments;
      logic               decimal_point;
      logic [POS_W-1:0]   digit_select;
      logic [BAND_W-1:0]  band;
      logic [ANGLE_W-1:0] servo_angle;
   } result_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset_tenths;
      logic [LIMIT_W-1:0]  low_limit_tenths;
      logic [LIMIT_W-1:0]  high_limit_tenths;
   } csr_type;

   function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] pattern;
      case (digit)
         4'd0:    pattern = 7'h3F;
         4'd1:    pattern = 7'h06;
         4'd2:    pattern = 7'h5B;
         4'd3:    pattern = 7'h4F;
         4'd4:    pattern = 7'h66;
         4'd5:    pattern = 7'h6D;
         4'd6:    pattern = 7'h7D;
         4'd7:    pattern = 7'h07;
         4'd8:    pattern = 7'h7F;
         4'd9:    pattern = 7'h6F;
         default: pattern = '0;
      endcase
      return pattern;
   endfunction

   function automatic logic [ANGLE_W-1:0] servo_of(input logic [BAND_W-1:0] band);
      logic [ANGLE_W-1:0] angle;
      case (band)
         BAND_LOW: angle = ANGLE_LOW;
         BAND_MID: angle = ANGLE_MID;
         default:  angle = ANGLE_HIGH;
      endcase
      return angle;
   endfunction

endpackage

FILE: hdl/tbd_front.sv
// front end: accepts items, multiplies samples by the scale numerator, and queues them
// depends on tbd_pkg

module tbd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          req_cmd,
   input  logic [tbd_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                          work_valid,
   output tbd_pkg::work_type             work,
   input  logic                          work_pop
);
   import tbd_pkg::*;

   work_type               queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   accept;
   work_type               entry;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign accept     = push && !full;
   assign work_valid = (count_ff != '0);
   assign work       = queue_ff[rd_ptr_ff];

   // ticks carry no product
   always_comb begin
      entry.cmd  = req_cmd;
      entry.prod = (req_cmd == CMD_TICK) ? '0
                                         : PROD_W'(req_sample) * PROD_W'(SCALE_NUM);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(accept);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(work_pop);
      count_in  = count_ff + QUEUE_CNT_W'(accept) - QUEUE_CNT_W'(work_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

FILE: hdl/tbd_back.sv
// back end: divides out the scale, classifies the band, splits digits and drives the display
// depends on tbd_pkg

module tbd_back (
   input  logic                clock,
   input  logic                reset,
   input  tbd_pkg::csr_type    csr,
   input  logic                work_valid,
   input  tbd_pkg::work_type   work,
   output logic                work_pop,
   input  logic                out_ready,
   output logic                out_write,
   output tbd_pkg::result_type out_item
);
   import tbd_pkg::*;

   logic advance;

   // stage a
   logic [QUOT_W-1:0]   quot_lo;
   logic [TEMP_W-1:0]   rem_sum;
   logic                rem_wrap;
   logic [REM_W-1:0]    rem;
   logic [QUOT_W-1:0]   quot;
   logic [TEMP_W-1:0]   temp;
   logic                low_hit, mid_hit;
   logic [BAND_W-1:0]   band_new;
   logic                is_sample;

   logic                a_valid_ff, a_valid_in;
   logic                a_cmd_ff;
   logic [TEMP_W-1:0]   a_temp_ff;
   logic [BAND_W-1:0]   a_band_ff, a_band_in;
   logic [BAND_W-1:0]   band_ff, band_in;

   // stage b
   logic                b_valid_ff;
   logic                b_cmd_ff;
   logic [TEMP_W-1:0]   b_temp_ff;
   logic [WHOLE_W-1:0]  b_whole_ff, b_whole_in;
   logic [HUNDREDS_W-1:0] b_q100_ff, b_q100_in;
   logic [BAND_W-1:0]   b_band_ff;

   // digit stage
   logic [DIGIT_W-1:0]  d_tenths, d_units, d_tens, d_hundreds;
   logic [DIGIT_W-1:0]  digit_store_ff [NUM_DIGITS];
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                show_tick;

   assign advance  = out_ready;
   assign work_pop = advance && work_valid;
   assign is_sample = (work.cmd == CMD_SAMPLE);

   // divide by 4095: prod = q*4096 + lo, so prod - q*4095 = lo + q, one correction
   always_comb begin
      quot_lo  = work.prod[PROD_W-1:DEN_SHIFT];
      rem_sum  = TEMP_W'(work.prod[DEN_SHIFT-1:0]) + TEMP_W'(quot_lo);
      rem_wrap = (rem_sum >= SCALE_DEN);
      rem      = rem_wrap ? REM_W'(rem_sum - SCALE_DEN) : rem_sum[REM_W-1:0];
      quot     = quot_lo + QUOT_W'(rem_wrap);
      temp     = TEMP_W'(quot) + TEMP_W'(csr.offset_tenths);
   end

   // exact compare: temp + rem/4095 <= limit
   always_comb begin
      low_hit = (temp < TEMP_W'(csr.low_limit_tenths)) ||
                ((temp == TEMP_W'(csr.low_limit_tenths)) && (rem == '0));
      mid_hit = (temp < TEMP_W'(csr.high_limit_tenths)) ||
                ((temp == TEMP_W'(csr.high_limit_tenths)) && (rem == '0));
      if (low_hit) begin
         band_new = BAND_LOW;
      end else if (mid_hit) begin
         band_new = BAND_MID;
      end else begin
         band_new = BAND_HIGH;
      end
      a_band_in  = is_sample ? band_new : band_ff;
      band_in    = (work_pop && is_sample) ? band_new : band_ff;
      a_valid_in = advance ? work_pop : a_valid_ff;
   end

   always_comb begin
      b_whole_in = WHOLE_W'((29'(a_temp_ff) * 29'(RECIP_10)) >> RECIP_SHIFT);
      b_q100_in  = HUNDREDS_W'((26'(a_temp_ff) * 26'(RECIP_100)) >> RECIP_SHIFT);
   end

   always_comb begin
      d_tenths   = DIGIT_W'(b_temp_ff - TEMP_W'(b_whole_ff) * TEMP_W'(DEC_BASE));
      d_units    = DIGIT_W'(b_whole_ff - WHOLE_W'(b_q100_ff) * WHOLE_W'(DEC_BASE));
      d_hundreds = DIGIT_W'((11'(b_q100_ff) * 11'(SMALL_RECIP)) >> SMALL_SHIFT);
      d_tens     = DIGIT_W'(b_q100_ff - HUNDREDS_W'(d_hundreds) * HUNDREDS_W'(DEC_BASE));
   end

   assign out_write = advance && b_valid_ff;
   assign show_tick = (b_cmd_ff == CMD_TICK);
   assign pos_in    = (out_write && show_tick) ? pos_ff + POS_W'(1) : pos_ff;

   always_comb begin
      out_item.segments      = show_tick ? seg_pattern(digit_store_ff[pos_ff]) : '0;
      out_item.decimal_point = show_tick && (pos_ff == POS_UNITS);
      out_item.digit_select  = pos_ff;
      out_item.band          = b_band_ff;
      out_item.servo_angle   = servo_of(b_band_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         band_ff    <= BAND_LOW;
         pos_ff     <= '0;
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digit_store_ff[i] <= '0;
         end
      end else begin
         a_valid_ff <= a_valid_in;
         if (advance) begin
            b_valid_ff <= a_valid_ff;
         end
         band_ff <= band_in;
         pos_ff  <= pos_in;
         if (out_write && !show_tick) begin
            digit_store_ff[0] <= d_hundreds;
            digit_store_ff[1] <= d_tens;
            digit_store_ff[2] <= d_units;
            digit_store_ff[3] <= d_tenths;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_cmd_ff   <= work.cmd;
         a_temp_ff  <= temp;
         a_band_ff  <= a_band_in;
         b_cmd_ff   <= a_cmd_ff;
         b_temp_ff  <= a_temp_ff;
         b_whole_ff <= b_whole_in;
         b_q100_ff  <= b_q100_in;
         b_band_ff  <= a_band_ff;
      end
   end

endmodule

FILE: hdl/tbd_out_queue.sv
// two-entry result queue between the back end and the result ports
// depends on tbd_pkg

module tbd_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                out_write,
   input  tbd_pkg::result_type out_item,
   output logic                out_ready,
   output logic                empty,
   input  logic                pop,
   output tbd_pkg::result_type head
);
   import tbd_pkg::*;

   result_type           entries_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [OUT_CNT_W-1:0] count_ff, count_in;
   logic                 take;

   assign out_ready = (count_ff != OUT_CNT_W'(OUT_DEPTH));
   assign empty     = (count_ff == '0);
   assign take      = pop && !empty;
   assign head      = entries_ff[rd_ptr_ff];
   assign count_in  = count_ff + OUT_CNT_W'(out_write) - OUT_CNT_W'(take);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + OUT_PTR_W'(out_write);
         rd_ptr_ff <= rd_ptr_ff + OUT_PTR_W'(take);
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_write) begin
         entries_ff[wr_ptr_ff] <= out_item;
      end
   end

endmodule

FILE: hdl/thermometer_band_and_digit_display_core.sv
// top level of the thermometer band classifier and seven-segment multiplexer
// depends on tbd_pkg, tbd_front, tbd_back, tbd_out_queue
//
//   channel   handshake        fields
//   --------  ---------------  -----------------------------------------------
//   request   push / full      req_cmd, req_sample
//   response  empty / pop      rsp_segments, rsp_decimal_point, rsp_digit_select,
//                              rsp_band, rsp_servo_angle
//   config    valid / ready    csr_index, csr_data (ready is always high)
//
// sustained rate is one item per cycle while the result queue is not full; an item
// taken passes through the four-entry input queue and the two-stage back end
// (divide and band compare, then reciprocal digit split) into the result queue,
// whose head drives the response ports
// a full result queue stalls the back end; the input queue then fills and raises full
// synchronous reset clears queues, band, digit position and digit store

module thermometer_band_and_digit_display_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic                            req_cmd,
   input  logic [tbd_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                            empty,
   input  logic                            pop,
   output logic [tbd_pkg::SEG_W-1:0]       rsp_segments,
   output logic                            rsp_decimal_point,
   output logic [tbd_pkg::POS_W-1:0]       rsp_digit_select,
   output logic [tbd_pkg::BAND_W-1:0]      rsp_band,
   output logic [tbd_pkg::ANGLE_W-1:0]     rsp_servo_angle,
   input  logic                            valid,
   output logic                            ready,
   input  logic [tbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tbd_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tbd_pkg::*;

   csr_type    csr_ff, csr_in;
   logic       work_valid, work_pop;
   work_type   work;
   logic       out_ready, out_write;
   result_type out_item, head;

   assign ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (valid) begin
         unique case (csr_index)
            CSR_OFFSET:     csr_in.offset_tenths     = csr_data[OFFSET_W-1:0];
            CSR_LOW_LIMIT:  csr_in.low_limit_tenths  = csr_data[LIMIT_W-1:0];
            CSR_HIGH_LIMIT: csr_in.high_limit_tenths = csr_data[LIMIT_W-1:0];
            default:        csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.offset_tenths     <= OFFSET_RESET;
         csr_ff.low_limit_tenths  <= LOW_LIMIT_RESET;
         csr_ff.high_limit_tenths <= HIGH_LIMIT_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   tbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_cmd    (req_cmd),
      .req_sample (req_sample),
      .work_valid (work_valid),
      .work       (work),
      .work_pop   (work_pop)
   );

   tbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .work_valid (work_valid),
      .work       (work),
      .work_pop   (work_pop),
      .out_ready  (out_ready),
      .out_write  (out_write),
      .out_item   (out_item)
   );

   tbd_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .out_write (out_write),
      .out_item  (out_item),
      .out_ready (out_ready),
      .empty     (empty),
      .pop       (pop),
      .head      (head)
   );

   assign rsp_segments      = head.segments;
   assign rsp_decimal_point = head.decimal_point;
   assign rsp_digit_select  = head.digit_select;
   assign rsp_band          = head.band;
   assign rsp_servo_angle   = head.servo_angle;

endmodule

FILE: hdl/tbd_checker.sv
// port-level checks for the thermometer display core, bound to the top level
// depends on tbd_pkg and thermometer_band_and_digit_display_core

module tbd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            full,
   input logic                            empty,
   input logic                            pop,
   input logic [tbd_pkg::SEG_W-1:0]       rsp_segments,
   input logic                            rsp_decimal_point,
   input logic [tbd_pkg::POS_W-1:0]       rsp_digit_select,
   input logic [tbd_pkg::BAND_W-1:0]      rsp_band,
   input logic [tbd_pkg::ANGLE_W-1:0]     rsp_servo_angle
);
   import tbd_pkg::*;

   // reset leaves no stale result and an open input
   a_reset_empty: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not cleared by reset");

   // servo angle always follows the reported band
   a_servo_band: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((rsp_band == BAND_LOW  && rsp_servo_angle == ANGLE_LOW) ||
                  (rsp_band == BAND_MID  && rsp_servo_angle == ANGLE_MID) ||
                  (rsp_band == BAND_HIGH && rsp_servo_angle == ANGLE_HIGH)))
      else $error("servo angle does not match band");

   // decimal point only on the units position
   a_dp_units: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_decimal_point) |-> (rsp_digit_select == POS_UNITS))
      else $error("decimal point off the units position");

   // a shown result that is not taken stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_segments) && $stable(rsp_band)))
      else $error("waiting result changed");

   // a lit decimal point always comes with a digit pattern
   a_dp_segments: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_decimal_point) |-> (rsp_segments != '0))
      else $error("decimal point shown with blank digit");

endmodule

bind thermometer_band_and_digit_display_core tbd_checker u_tbd_checker (.*);

FILE: tb/tb_top.sv
// testbench for the thermometer band classifier and seven-segment multiplexer core
// drives samples and ticks with random gaps, plus register writes; an internal tracker predicts
// every result frame; depends on tbd_pkg and thermometer_band_and_digit_display_core

module tb_top;
   import tbd_pkg::*;

   localparam int STALL_LIMIT   = 4000;
   localparam int SETTING_COUNT = 10;
   localparam int PHASE_ITEMS   = 150;
   localparam int QUIET_PHASE   = 4;
   localparam int MAX_REPORTS   = 30;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // tracks the display state and holds the frames still owed by the core
   class reading_tracker;
      logic [OFFSET_W-1:0] offset_t;
      logic [LIMIT_W-1:0]  low_lim;
      logic [LIMIT_W-1:0]  high_lim;
      logic [DIGIT_W-1:0]  digit_mem [NUM_DIGITS];
      logic [POS_W-1:0]    position;
      logic [BAND_W-1:0]   cur_band;
      result_type          pending_frames[$];
      int                  errors;
      int                  samples_seen;
      int                  ticks_seen;
      int                  writes_seen;

      function new();
         offset_t = OFFSET_RESET;
         low_lim  = LOW_LIMIT_RESET;
         high_lim = HIGH_LIMIT_RESET;
         foreach (digit_mem[i]) digit_mem[i] = '0;
         position     = '0;
         cur_band     = BAND_LOW;
         errors       = 0;
         samples_seen = 0;
         ticks_seen   = 0;
         writes_seen  = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         writes_seen++;
         case (idx)
            CSR_OFFSET:     offset_t = data[OFFSET_W-1:0];
            CSR_LOW_LIMIT:  low_lim  = data;
            CSR_HIGH_LIMIT: high_lim = data;
            default: ;
         endcase
      endfunction

      function logic [SEG_W-1:0] glyph(logic [DIGIT_W-1:0] d);
         case (d)
            4'd0:    return 7'b0111111;
            4'd1:    return 7'b0000110;
            4'd2:    return 7'b1011011;
            4'd3:    return 7'b1001111;
            4'd4:    return 7'b1100110;
            4'd5:    return 7'b1101101;
            4'd6:    return 7'b1111101;
            4'd7:    return 7'b0000111;
            4'd8:    return 7'b1111111;
            4'd9:    return 7'b1101111;
            default: return '0;
         endcase
      endfunction

      function logic [ANGLE_W-1:0] angle_for(logic [BAND_W-1:0] b);
         if (b == BAND_LOW) return ANGLE_LOW;
         if (b == BAND_MID) return ANGLE_MID;
         return ANGLE_HIGH;
      endfunction

      function void apply_item(logic cmd, logic [SAMPLE_W-1:0] smp);
         result_type  frame;
         int unsigned scaled;
         int unsigned tenths;
         int unsigned whole;
         int unsigned low_scaled;
         int unsigned high_scaled;
         frame = '0;
         frame.digit_select = position;
         if (cmd == CMD_SAMPLE) begin
            samples_seen++;
            // exact rational temperature, numerator over the full-scale count
            scaled      = int'(smp) * int'(SCALE_NUM) + int'(offset_t) * int'(SCALE_DEN);
            low_scaled  = int'(low_lim) * int'(SCALE_DEN);
            high_scaled = int'(high_lim) * int'(SCALE_DEN);
            tenths      = scaled / int'(SCALE_DEN);
            whole       = tenths / 10;
            if (scaled <= low_scaled) cur_band = BAND_LOW;
            else if (scaled <= high_scaled) cur_band = BAND_MID;
            else cur_band = BAND_HIGH;
            digit_mem[0] = 4'(whole / 100);
            digit_mem[1] = 4'((whole / 10) % 10);
            digit_mem[2] = 4'(whole % 10);
            digit_mem[3] = 4'(tenths % 10);
         end else begin
            ticks_seen++;
            frame.segments      = glyph(digit_mem[position]);
            frame.decimal_point = (position == POS_UNITS);
            position            = position + 1'b1;
         end
         frame.band        = cur_band;
         frame.servo_angle = angle_for(cur_band);
         pending_frames.push_back(frame);
      endfunction

      function void compare(string name, int want, int got);
         if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         end
      endfunction

      function void match_frame(result_type got);
         result_type want;
         if (pending_frames.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: frame with nothing owed, expected none got %h", $time, got);
            return;
         end
         want = pending_frames.pop_front();
         compare("segments", want.segments, got.segments);
         compare("decimal_point", want.decimal_point, got.decimal_point);
         compare("digit_select", want.digit_select, got.digit_select);
         compare("band", want.band, got.band);
         compare("servo_angle", want.servo_angle, got.servo_angle);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   push;
   logic                   full;
   logic                   req_cmd;
   logic [SAMPLE_W-1:0]    req_sample;
   logic                   empty;
   logic                   pop = 1'b0;
   logic [SEG_W-1:0]       rsp_segments;
   logic                   rsp_decimal_point;
   logic [POS_W-1:0]       rsp_digit_select;
   logic [BAND_W-1:0]      rsp_band;
   logic [ANGLE_W-1:0]     rsp_servo_angle;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   int req_idle_pct = 8;
   int rsp_idle_pct = 8;
   int quiet_cycles = 0;

   reading_tracker readings = new();

   thermometer_band_and_digit_display_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_cmd           (req_cmd),
      .req_sample        (req_sample),
      .empty             (empty),
      .pop               (pop),
      .rsp_segments      (rsp_segments),
      .rsp_decimal_point (rsp_decimal_point),
      .rsp_digit_select  (rsp_digit_select),
      .rsp_band          (rsp_band),
      .rsp_servo_angle   (rsp_servo_angle),
      .valid             (valid),
      .ready             (ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (valid && ready) readings.write_reg(csr_index, csr_data);
         if (push && !full) readings.apply_item(req_cmd, req_sample);
         if (pop && !empty)
            readings.match_frame('{segments: rsp_segments, decimal_point: rsp_decimal_point,
                                   digit_select: rsp_digit_select, band: rsp_band,
                                   servo_angle: rsp_servo_angle});
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || (valid && ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("tb_top: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic send_item(input logic cmd, input logic [SAMPLE_W-1:0] smp);
      while ($urandom_range(99) < req_idle_pct) begin
         push       = 1'b0;
         req_cmd    = 1'($urandom);
         req_sample = 12'($urandom);
         @(negedge clock);
      end
      push       = 1'b1;
      req_cmd    = cmd;
      req_sample = smp;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      push = 1'b0;
      while (readings.pending_frames.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      valid     = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      while (!ready) @(posedge clock);
      @(negedge clock);
      valid = 1'b0;
   endtask

   // sample within two counts of the one whose temperature lands on a limit, clamped to 0..4095
   function automatic logic [SAMPLE_W-1:0] sample_near(input int lim_tenths);
      int s;
      s = (lim_tenths - int'(readings.offset_t)) * int'(SCALE_DEN) / int'(SCALE_NUM);
      s = s + int'($urandom_range(4)) - 2;
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      return 12'(s);
   endfunction

   task automatic setup_phase(input int ph);
      int off_w;
      int lo_w;
      int hi_w;
      case (ph)
         0: begin   // offset masked to its width, both limits at full scale
            off_w = 4095;
            lo_w  = 4095;
            hi_w  = 4095;
         end
         1: begin   // every reading high
            off_w = 1000;
            lo_w  = 0;
            hi_w  = 0;
         end
         2: begin   // high limit under low limit, no middle band
            off_w = 500;
            lo_w  = 2000;
            hi_w  = 1000;
         end
         default: begin
            off_w = ($urandom_range(3) == 0) ? int'($urandom_range(4095))
                                             : int'($urandom_range(1000));
            lo_w  = (off_w % 1024) + int'($urandom_range(3300));
            if (lo_w > 4095) lo_w = 4095;
            hi_w  = ($urandom_range(3) == 0) ? int'($urandom_range(4095))
                                             : lo_w + int'($urandom_range(80));
            if (hi_w > 4095) hi_w = 4095;
         end
      endcase
      wait_drained();
      write_csr(CSR_OFFSET, 12'(off_w));
      write_csr(CSR_LOW_LIMIT, 12'(lo_w));
      write_csr(CSR_HIGH_LIMIT, 12'(hi_w));
      if (ph == 3 || $urandom_range(1) == 1) write_csr(CSR_UNUSED, 12'($urandom));
   endtask

   initial begin
      int                  ph;
      int                  k;
      int                  pick;
      logic [SAMPLE_W-1:0] smp;
      reset      = 1'b1;
      push       = 1'b0;
      req_cmd    = CMD_SAMPLE;
      req_sample = '0;
      valid      = 1'b0;
      csr_index  = CSR_OFFSET;
      csr_data   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: tick before any sample, extremes, band edges
      send_item(CMD_TICK, 12'hFFF);
      send_item(CMD_SAMPLE, 12'd4095);
      repeat (4) send_item(CMD_TICK, 12'h000);
      send_item(CMD_SAMPLE, 12'd0);
      send_item(CMD_SAMPLE, 12'd136);
      send_item(CMD_SAMPLE, 12'd137);
      send_item(CMD_SAMPLE, 12'd142);
      send_item(CMD_SAMPLE, 12'd143);
      send_item(CMD_SAMPLE, 12'hAAA);
      send_item(CMD_SAMPLE, 12'h555);
      send_item(CMD_TICK, 12'h555);

      // temperature exactly on the low limit stays low, one count more is middle
      wait_drained();
      write_csr(CSR_OFFSET, 12'd0);
      write_csr(CSR_LOW_LIMIT, 12'd220);
      write_csr(CSR_HIGH_LIMIT, 12'd4095);
      send_item(CMD_SAMPLE, 12'd273);
      send_item(CMD_SAMPLE, 12'd274);
      repeat (4) send_item(CMD_TICK, 12'd0);

      for (ph = 0; ph < SETTING_COUNT; ph++) begin
         setup_phase(ph);
         if (ph == QUIET_PHASE) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         for (k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(7);
            if (pick < 2) smp = sample_near(int'(readings.low_lim));
            else if (pick < 4) smp = sample_near(int'(readings.high_lim));
            else smp = 12'($urandom);
            send_item(1'($urandom), smp);
            if ($urandom_range(59) == 0) wait_drained();
         end
         req_idle_pct = 8;
         rsp_idle_pct = 8;
      end

      wait_drained();
      repeat (12) @(posedge clock);
      if (readings.pending_frames.size() != 0) readings.errors++;
      $display("summary: %0d samples and %0d ticks checked under %0d register settings",
               readings.samples_seen, readings.ticks_seen, SETTING_COUNT + 2);
      $display("summary: %0d register writes, %0d mismatches", readings.writes_seen,
               readings.errors);
      if (readings.errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/tbd_pkg.sv
hdl/tbd_front.sv
hdl/tbd_back.sv
hdl/tbd_out_queue.sv
hdl/thermometer_band_and_digit_display_core.sv
hdl/tbd_checker.sv
tb/tb_top.sv
